// ===== hdl/ctr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared types, constants and helpers of the chunk time remapper.
// ----------------------------------------------------------------------------
package ctr_pkg;

  localparam int MaxSegments = 64;
  localparam int AddrW       = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int CntW        = $clog2(MaxSegments + 1);
  localparam int TimeW       = 32;
  localparam int LenW        = 10;
  localparam int KindW       = 2;
  localparam int LimW        = 14;
  localparam int ProdW       = LenW + 9;

  localparam logic [KindW-1:0] KindClear  = 2'd0;
  localparam logic [KindW-1:0] KindAppend = 2'd1;
  localparam logic [KindW-1:0] KindMap    = 2'd2;

  localparam logic [TimeW-1:0] MinSpanMs    = 32'd300;
  localparam logic [LimW-1:0]  SpanFloorMs  = 14'd4000;
  localparam logic [ProdW-1:0] SpanPerChar  = 19'd350;
  localparam logic [LimW-1:0]  SpanCeilMs   = 14'd10000;

  typedef struct packed {
    logic [TimeW-1:0] cb;
    logic [TimeW-1:0] cf;
    logic [TimeW-1:0] sb;
    logic [TimeW-1:0] sf;
  } ctr_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic             clear;
    logic             append;
    logic             capture;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             load_prev;
    logic             eval;
    logic             has_next;
    logic             phase;     // 0: start time, 1: end time
    logic [AddrW-1:0] cur_idx;
    logic             fin1;
    logic             fin2;
    logic             out_load;
  } ctr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            hit;
  } ctr_stat_t;

  // bound(4000, 350 * max(1, len), 10000)
  function automatic logic [LimW-1:0] span_limit(input logic [LenW-1:0] len);
    logic [LenW-1:0]  l1;
    logic [ProdW-1:0] prod;
    l1   = (len == '0) ? LenW'(1) : len;
    prod = ProdW'(l1) * SpanPerChar;
    if (prod < ProdW'(SpanFloorMs)) begin
      return SpanFloorMs;
    end else if (prod > ProdW'(SpanCeilMs)) begin
      return SpanCeilMs;
    end
    return prod[LimW-1:0];
  endfunction

endpackage

// ===== hdl/ctr_if.sv =====
// ----------------------------------------------------------------------------
// ctr_if
// Valid/ready channels of the chunk time remapper: request input, result
// output and the duration write port.
// ----------------------------------------------------------------------------
interface ctr_in_if
  import ctr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [TimeW-1:0] seg_chunk_begin;
  logic [TimeW-1:0] seg_chunk_finish;
  logic [TimeW-1:0] seg_source_begin;
  logic [TimeW-1:0] seg_source_finish;
  logic [TimeW-1:0] sub_start;
  logic [TimeW-1:0] sub_end;
  logic [LenW-1:0]  text_length;

  modport source (output valid, kind, seg_chunk_begin, seg_chunk_finish, seg_source_begin,
                  seg_source_finish, sub_start, sub_end, text_length, input ready);
  modport sink   (input valid, kind, seg_chunk_begin, seg_chunk_finish, seg_source_begin,
                  seg_source_finish, sub_start, sub_end, text_length, output ready);
endinterface

interface ctr_out_if
  import ctr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] mapped_start;
  logic [TimeW-1:0] mapped_end;
  logic             keep;
  logic             table_overflowed;

  modport source (output valid, mapped_start, mapped_end, keep, table_overflowed,
                  input ready);
  modport sink   (input valid, mapped_start, mapped_end, keep, table_overflowed,
                  output ready);
endinterface

interface ctr_cfg_if
  import ctr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/ctr_datapath.sv =====
// ----------------------------------------------------------------------------
// ctr_datapath
// Segment table memory, walk evaluator, clamp / span limit / repair stages
// and the result register.
// ----------------------------------------------------------------------------
module ctr_datapath
  import ctr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctr_cmd_t         cmd_i,
  output ctr_stat_t        stat_o,
  input  logic             cfg_valid_i,
  input  logic [TimeW-1:0] cfg_data_i,
  input  logic [TimeW-1:0] seg_chunk_begin_i,
  input  logic [TimeW-1:0] seg_chunk_finish_i,
  input  logic [TimeW-1:0] seg_source_begin_i,
  input  logic [TimeW-1:0] seg_source_finish_i,
  input  logic [TimeW-1:0] sub_start_i,
  input  logic [TimeW-1:0] sub_end_i,
  input  logic [LenW-1:0]  text_length_i,
  output logic [TimeW-1:0] mapped_start_o,
  output logic [TimeW-1:0] mapped_end_o,
  output logic             keep_o,
  output logic             table_overflowed_o
);

  // control state
  logic [CntW-1:0]  cnt_q;
  logic             ovf_q;
  logic [TimeW-1:0] dur_q;

  // table
  ctr_entry_t       tab_q [MaxSegments];
  ctr_entry_t       rd_q;
  ctr_entry_t       prev_q;

  // item state
  logic [TimeW-1:0] st_in_q, en_in_q;
  logic [LenW-1:0]  len_q;
  logic             have_seg_q;
  logic [TimeW:0]   st_raw_q, en_raw_q;
  logic [AddrW-1:0] s_seg_q, e_seg_q;
  logic [TimeW-1:0] cut_q;
  logic [TimeW-1:0] st_c_q, en_c_q;
  logic [LimW-1:0]  lim_q;

  // result
  logic [TimeW-1:0] ms_q, me_q;
  logic             keep_q, ovf_out_q;

  // walk evaluation
  logic [TimeW-1:0] t;
  logic             lt_cb, le_cf, in_gap, hit;
  logic [TimeW-1:0] d_prev, d_next;
  logic [TimeW:0]   res;
  logic [AddrW-1:0] seg;
  logic [TimeW-1:0] cut;

  always_comb begin
    t      = cmd_i.phase ? en_in_q : st_in_q;
    lt_cb  = t < prev_q.cb;
    le_cf  = t <= prev_q.cf;
    in_gap = cmd_i.has_next && (t < rd_q.cb);
    d_prev = t - prev_q.cf;
    d_next = rd_q.cb - t;
    hit    = lt_cb || le_cf || in_gap || !cmd_i.has_next;
    seg    = cmd_i.cur_idx;
    cut    = prev_q.sf;
    priority if (lt_cb) begin
      res = {1'b0, prev_q.sb};
    end else if (le_cf) begin
      res = {1'b0, prev_q.sb} + {1'b0, t - prev_q.cb};
    end else if (in_gap) begin
      if (d_prev <= d_next) begin
        res = {1'b0, prev_q.sf};
      end else begin
        res = {1'b0, rd_q.sb};
        seg = cmd_i.cur_idx + AddrW'(1);
        cut = rd_q.sf;
      end
    end else begin
      res = {1'b0, prev_q.sf};
    end
  end

  assign stat_o.cnt = cnt_q;
  assign stat_o.hit = hit;

  // finishing stages
  logic             table_full;
  logic             do_cut;
  logic [TimeW:0]   alt;
  logic [TimeW-1:0] en_fix, en_out;
  logic             keep_d;

  assign table_full = cnt_q >= CntW'(MaxSegments);

  always_comb begin
    do_cut = have_seg_q && (s_seg_q != e_seg_q) && (en_c_q > st_c_q) &&
             ((en_c_q - st_c_q) > TimeW'(lim_q)) && (cut_q < en_c_q);
    alt    = {1'b0, st_c_q} + {1'b0, MinSpanMs};
    en_fix = (alt < {1'b0, dur_q}) ? alt[TimeW-1:0] : dur_q;
    en_out = (en_c_q > st_c_q) ? en_c_q : en_fix;
    // repaired end is after start exactly when the duration is
    keep_d = (len_q != '0) && ((en_c_q > st_c_q) || (dur_q > st_c_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      dur_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        dur_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.append) begin
        if (table_full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !table_full) begin
      tab_q[cnt_q[AddrW-1:0]] <= '{cb: seg_chunk_begin_i, cf: seg_chunk_finish_i,
                                   sb: seg_source_begin_i, sf: seg_source_finish_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= tab_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prev) begin
      prev_q <= rd_q;
    end
    if (cmd_i.capture) begin
      st_in_q    <= sub_start_i;
      en_in_q    <= sub_end_i;
      st_raw_q   <= {1'b0, sub_start_i};
      en_raw_q   <= {1'b0, sub_end_i};
      len_q      <= text_length_i;
      have_seg_q <= cnt_q != '0;
    end
    if (cmd_i.eval && hit) begin
      if (cmd_i.phase) begin
        en_raw_q <= res;
        e_seg_q  <= seg;
      end else begin
        st_raw_q <= res;
        s_seg_q  <= seg;
        cut_q    <= cut;
      end
    end
    if (cmd_i.fin1) begin
      st_c_q <= (st_raw_q > {1'b0, dur_q}) ? dur_q : st_raw_q[TimeW-1:0];
      en_c_q <= (en_raw_q > {1'b0, dur_q}) ? dur_q : en_raw_q[TimeW-1:0];
      lim_q  <= span_limit(len_q);
    end
    if (cmd_i.fin2 && do_cut) begin
      en_c_q <= cut_q;
    end
    if (cmd_i.out_load) begin
      ms_q      <= st_c_q;
      me_q      <= en_out;
      keep_q    <= keep_d;
      ovf_out_q <= ovf_q;
    end
  end

  assign mapped_start_o     = ms_q;
  assign mapped_end_o       = me_q;
  assign keep_o             = keep_q;
  assign table_overflowed_o = ovf_out_q;

endmodule

// ===== hdl/ctr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctr_ctrl
// Sequencer: takes requests, steps the table walk for start and end times,
// runs the finishing stages and owns the result valid.
// ----------------------------------------------------------------------------
module ctr_ctrl
  import ctr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [KindW-1:0] kind_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ctr_cmd_t         cmd_o,
  input  ctr_stat_t        stat_i
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD0   = 8'b0000_0010,
    S_FIRST = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_LAST  = 8'b0001_0000,
    S_FIN1  = 8'b0010_0000,
    S_FIN2  = 8'b0100_0000,
    S_FIN3  = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;       // next read address
  logic [AddrW-1:0] cur_q, cur_d;       // entry held in the walk register
  logic             phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             more;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign more       = idx_q < stat_i.cnt;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.phase   = phase_q;
    cmd_o.cur_idx = cur_q;
    cmd_o.rd_addr = idx_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KindClear:  cmd_o.clear  = 1'b1;
            KindAppend: cmd_o.append = 1'b1;
            KindMap: begin
              cmd_o.capture = 1'b1;
              phase_d       = 1'b0;
              state_d       = (stat_i.cnt != '0) ? S_RD0 : S_FIN1;
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
        idx_d         = CntW'(1);
        state_d       = S_FIRST;
      end
      S_FIRST: begin
        cmd_o.load_prev = 1'b1;
        cur_d           = '0;
        if (more) begin
          cmd_o.rd_en = 1'b1;
          idx_d       = idx_q + CntW'(1);
          state_d     = S_WALK;
        end else begin
          state_d = S_LAST;
        end
      end
      S_WALK: begin
        cmd_o.eval     = 1'b1;
        cmd_o.has_next = 1'b1;
        if (stat_i.hit) begin
          phase_d = 1'b1;
          state_d = phase_q ? S_FIN1 : S_RD0;
        end else begin
          cmd_o.load_prev = 1'b1;
          cur_d           = cur_q + AddrW'(1);
          if (more) begin
            cmd_o.rd_en = 1'b1;
            idx_d       = idx_q + CntW'(1);
          end else begin
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        cmd_o.eval = 1'b1;
        phase_d    = 1'b1;
        state_d    = phase_q ? S_FIN1 : S_RD0;
      end
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = S_FIN3;
      end
      S_FIN3: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cur_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cur_q       <= cur_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rd_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (CntW'(cmd_o.rd_addr) < stat_i.cnt))
    else $error("table read beyond filled entries");

  a_walk_has_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ((CntW'(cur_q) + CntW'(1)) < stat_i.cnt))
    else $error("walk step without a following entry");

  a_last_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |-> stat_i.hit)
    else $error("last entry did not resolve the time");

  a_empty_skips_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KindMap) && (stat_i.cnt == '0)) |=> (state_q == S_FIN1))
    else $error("map on empty table entered the walk");

  a_result_from_fin3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN3))
    else $error("result valid raised outside final stage");

endmodule

// ===== hdl/chunk_time_remapper_core.sv =====
// ----------------------------------------------------------------------------
// chunk_time_remapper_core
// Maps subtitle times from a packed audio chunk back to source audio time.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   request channel. kind clear empties the segment table, append adds
//          one segment (dropped with a sticky overflow flag once full), map
//          takes sub_start/sub_end/text_length and yields one result.
//   out_o  one result per map request: mapped times, keep, overflow flag.
//   cfg_i  audio duration write, always ready; write only while idle.
// Timing:
//   clear and append complete in the idle state. For a map, the single
//   read port of the table memory delivers one entry per cycle, walked
//   once for the start and once for the end time, followed by three
//   finishing stages. On an empty table the walk is skipped.
//   One request is in flight at a time; a new request is taken once the
//   previous map has placed its result in the output register.
// Reset: empties the table, clears the overflow flag and sets the duration
//   to zero. Table contents are not cleared.
// Stall: a held result stays in the output register; clear and append are
//   still taken, and the next map waits in its last stage for the slot.
// ----------------------------------------------------------------------------
module chunk_time_remapper_core
  import ctr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ctr_in_if.sink       in_i,
  ctr_out_if.source    out_o,
  ctr_cfg_if.sink      cfg_i
);

  ctr_cmd_t  cmd;
  ctr_stat_t stat;

  assign cfg_i.ready = 1'b1;

  ctr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .kind_i      (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ctr_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_data_i          (cfg_i.data),
    .seg_chunk_begin_i   (in_i.seg_chunk_begin),
    .seg_chunk_finish_i  (in_i.seg_chunk_finish),
    .seg_source_begin_i  (in_i.seg_source_begin),
    .seg_source_finish_i (in_i.seg_source_finish),
    .sub_start_i         (in_i.sub_start),
    .sub_end_i           (in_i.sub_end),
    .text_length_i       (in_i.text_length),
    .mapped_start_o      (out_o.mapped_start),
    .mapped_end_o        (out_o.mapped_end),
    .keep_o              (out_o.keep),
    .table_overflowed_o  (out_o.table_overflowed)
  );

endmodule
